@@ design/ikd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ikd_pkg;

  // Input item: one heartbeat tick
  typedef struct packed {
    logic dit_pressed;
    logic dah_pressed;
    logic word_detect;
  } in_item_t;

  // Result item: one per tick
  typedef struct packed {
    logic       tx_line;
    logic       sidetone_on;
    logic       char_valid;
    logic [6:0] char_code;
    logic       tx_start;
    logic       rx_return;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [1:0] keyer_mode;
    logic       paddle_swap;
    logic [7:0] beats_per_dot;
    logic       tx_key_enable;
    logic       sidetone_enable;
    logic       tx_invert;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_KEYED = 2'd1,
    PH_GAP   = 2'd2
  } phase_t;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_KEYER_MODE      = 3'd0;
  localparam logic [2:0] CFG_PADDLE_SWAP     = 3'd1;
  localparam logic [2:0] CFG_BEATS_PER_DOT   = 3'd2;
  localparam logic [2:0] CFG_TX_KEY_ENABLE   = 3'd3;
  localparam logic [2:0] CFG_SIDETONE_ENABLE = 3'd4;
  localparam logic [2:0] CFG_TX_INVERT       = 3'd5;

  // Keyer modes
  localparam logic [1:0] MODE_IAMBIC_A     = 2'd0;
  localparam logic [1:0] MODE_IAMBIC_B     = 2'd1;
  localparam logic [1:0] MODE_ULTIMATIC    = 2'd2;
  localparam logic [1:0] MODE_DAH_PRIORITY = 2'd3;

  // Paddle latch bits
  localparam logic [1:0] LATCH_DIT  = 2'b01;
  localparam logic [1:0] LATCH_DAH  = 2'b10;
  localparam logic [1:0] LATCH_BOTH = 2'b11;

  localparam logic [6:0] ASCII_SPACE = 7'h20;
  localparam int         MORSE_LEN   = 42;

  // Left-aligned element patterns with a stop bit, 1 = dah
  localparam logic [7:0] MORSE_PATTERNS [MORSE_LEN] = '{
    8'hFC, 8'h7C, 8'h3C, 8'h1C, 8'h0C, 8'h04, 8'h84, 8'hC4, 8'hE4, 8'hF4,
    8'h60, 8'h88, 8'hA8, 8'h90, 8'h40, 8'h28, 8'hD0, 8'h08, 8'h20, 8'h78,
    8'hB0, 8'h48, 8'hE0, 8'hA0, 8'hF0, 8'h68, 8'hD8, 8'h50, 8'h10, 8'hC0,
    8'h30, 8'h18, 8'h70, 8'h98, 8'hB8, 8'hC8,
    8'h32, 8'h8C, 8'h56, 8'h16, 8'h54, 8'h94
  };

  // ASCII for each pattern: digits, letters, then ? = . # $ /
  localparam logic [6:0] MORSE_ASCII [MORSE_LEN] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
    7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
    7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
    7'h3F, 7'h3D, 7'h2E, 7'h23, 7'h24, 7'h2F
  };

endpackage

`default_nettype wire

@@ design/ikd_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ikd_decode (
  input  wire logic [7:0] pattern,
  output logic      [6:0] char_code
);
  import ikd_pkg::*;

  // Match the pattern against every table entry, lowest index wins
  always_comb begin
    char_code = '0;
    for (int i = MORSE_LEN - 1; i >= 0; i--) begin
      if (pattern == MORSE_PATTERNS[i]) begin
        char_code = MORSE_ASCII[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/ikd_keyer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ikd_keyer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire ikd_pkg::in_item_t  item,
  input  wire ikd_pkg::cfg_t      cfg,
  output ikd_pkg::out_item_t      result
);
  import ikd_pkg::*;

  phase_t      phase, phase_next;
  logic [9:0]  countdown, countdown_next;
  logic [7:0]  element_bits, element_bits_next;
  logic [3:0]  element_count, element_count_next;
  logic        word_gap_pending, word_gap_pending_next;
  logic [1:0]  paddle_latches, paddle_latches_next;
  logic [1:0]  last_element, last_element_next;
  logic [1:0]  ultimatic_memory, ultimatic_memory_next;
  logic        tx_level, tx_level_next;
  logic        tone_level, tone_level_next;

  logic [15:0] pattern_wide;
  logic [7:0]  pattern;
  logic [6:0]  decoded;

  // Left-align the sent elements behind a stop bit
  assign pattern_wide = {7'd0, element_bits, 1'b1} << (3'd7 - element_count[2:0]);
  assign pattern      = pattern_wide[7:0];

  ikd_decode u_decode (
    .pattern   (pattern),
    .char_code (decoded)
  );

  // State registers, advanced once per tick item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      countdown        <= '0;
      element_bits     <= '0;
      element_count    <= '0;
      word_gap_pending <= 1'b0;
      paddle_latches   <= '0;
      last_element     <= '0;
      ultimatic_memory <= '0;
      tx_level         <= 1'b0;
      tone_level       <= 1'b0;
    end else if (fire) begin
      phase            <= phase_next;
      countdown        <= countdown_next;
      element_bits     <= element_bits_next;
      element_count    <= element_count_next;
      word_gap_pending <= word_gap_pending_next;
      paddle_latches   <= paddle_latches_next;
      last_element     <= last_element_next;
      ultimatic_memory <= ultimatic_memory_next;
      tx_level         <= tx_level_next;
      tone_level       <= tone_level_next;
    end
  end

  // Next state and result for one tick
  always_comb begin
    logic [9:0] cd;
    logic [9:0] dot;
    logic [1:0] lat;
    logic [1:0] sampled;
    logic [1:0] dit_mask;
    logic [1:0] dah_mask;

    dot      = {2'b00, cfg.beats_per_dot};
    cd       = (countdown != '0) ? countdown - 10'd1 : '0;
    dit_mask = item.dit_pressed ? (cfg.paddle_swap ? LATCH_DAH : LATCH_DIT) : 2'b00;
    dah_mask = item.dah_pressed ? (cfg.paddle_swap ? LATCH_DIT : LATCH_DAH) : 2'b00;
    lat      = paddle_latches;
    sampled  = paddle_latches | dit_mask | dah_mask;

    phase_next            = phase;
    countdown_next        = cd;
    element_bits_next     = element_bits;
    element_count_next    = element_count;
    word_gap_pending_next = item.word_detect ? word_gap_pending : 1'b0;
    last_element_next     = last_element;
    ultimatic_memory_next = ultimatic_memory;
    tx_level_next         = tx_level;
    tone_level_next       = tone_level;

    result = '0;

    case (phase)
      PH_KEYED: begin
        if (cfg.keyer_mode == MODE_IAMBIC_B) begin
          lat = sampled;
        end
        // Element done: key up and time the inter-element gap
        if (cd == '0) begin
          if (cfg.sidetone_enable) tone_level_next = 1'b0;
          if (cfg.tx_key_enable) tx_level_next = 1'b0;
          countdown_next = dot;
          phase_next     = PH_GAP;
        end
      end
      PH_GAP: begin
        lat = sampled;
        if (cd == '0) begin
          phase_next       = PH_IDLE;
          countdown_next   = dot;
          result.rx_return = ~item.word_detect;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        lat        = sampled;
        // Resolve squeezes per keyer mode
        if (cfg.keyer_mode == MODE_IAMBIC_A || cfg.keyer_mode == MODE_IAMBIC_B) begin
          lat               = lat & ~last_element;
          last_element_next = '0;
        end else if (cfg.keyer_mode == MODE_ULTIMATIC) begin
          if (lat == LATCH_BOTH) begin
            if (ultimatic_memory != '0) lat = lat & ~ultimatic_memory;
            else lat = lat & LATCH_DAH;
          end else begin
            ultimatic_memory_next = lat;
          end
        end else begin
          if (lat == LATCH_BOTH) lat = LATCH_DAH;
        end

        if (cd == '0 && element_count != '0) begin
          // Character gap: report the decoded pattern, zero past seven elements
          result.char_valid     = 1'b1;
          result.char_code      = (element_count > 4'd7) ? 7'd0 : decoded;
          element_bits_next     = '0;
          element_count_next    = '0;
          countdown_next        = {dot[7:0], 2'b00};
          word_gap_pending_next = 1'b1;
        end else if (cd == '0 && word_gap_pending_next) begin
          // Word gap: report a space
          word_gap_pending_next = 1'b0;
          result.char_valid     = 1'b1;
          result.char_code      = ASCII_SPACE;
        end else if (lat != '0) begin
          // Start the next element, dit first
          word_gap_pending_next = 1'b0;
          if (element_count != 4'd15) element_count_next = element_count + 4'd1;
          element_bits_next = {element_bits[6:0], 1'b0};
          if (lat[0]) begin
            countdown_next    = dot;
            last_element_next = LATCH_DIT;
          end else begin
            countdown_next       = dot + {dot[8:0], 1'b0};
            last_element_next    = LATCH_DAH;
            element_bits_next[0] = 1'b1;
          end
          result.tx_start = ~item.word_detect;
          if (cfg.sidetone_enable) tone_level_next = 1'b1;
          if (cfg.tx_key_enable) tx_level_next = 1'b1;
          lat        = '0;
          phase_next = PH_KEYED;
        end
      end
    endcase

    paddle_latches_next = lat;
    result.tx_line      = tx_level_next ^ cfg.tx_invert;
    result.sidetone_on  = tone_level_next;
  end

endmodule

`default_nettype wire

@@ design/iambic_keyer_with_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// From input accept to result visible: input register, then result register.
// Throughput: one tick item per cycle unless stalled; the keyer step is one pass of logic per item.
// A stalled result keeps the next item in the input register and drops in_ready until taken.
// Reset (synchronous, active high): keyer idle, counters and latches clear,
// registers return to mode 0, no swap, 12 beats per dot, tx and sidetone enabled, no invert.
module iambic_keyer_with_decoder_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ikd_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ikd_pkg::out_item_t       out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [7:0]          cfg_data
);
  import ikd_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_full;
  logic      advance;
  out_item_t result;

  assign cfg_ready = 1'b1;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keyer_mode      <= MODE_IAMBIC_A;
      cfg.paddle_swap     <= 1'b0;
      cfg.beats_per_dot   <= 8'd12;
      cfg.tx_key_enable   <= 1'b1;
      cfg.sidetone_enable <= 1'b1;
      cfg.tx_invert       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEYER_MODE:      cfg.keyer_mode      <= cfg_data[1:0];
        CFG_PADDLE_SWAP:     cfg.paddle_swap     <= cfg_data[0];
        CFG_BEATS_PER_DOT:   cfg.beats_per_dot   <= cfg_data;
        CFG_TX_KEY_ENABLE:   cfg.tx_key_enable   <= cfg_data[0];
        CFG_SIDETONE_ENABLE: cfg.sidetone_enable <= cfg_data[0];
        CFG_TX_INVERT:       cfg.tx_invert       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the held item when the result slot is free or draining
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  ikd_keyer u_keyer (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  // Register the result item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import ikd_pkg::*;

  localparam int LIMIT_NS = 6_000_000;
  localparam int N_PHASES = 13;
  localparam int N_ROWS = 24;

  // Element patterns, left aligned with a stop bit, 1 = dah:
  // digits 0-9, letters A-Z, then the punctuation below
  localparam logic [7:0] SENT_PATTERNS [42] = '{
    8'hFC, 8'h7C, 8'h3C, 8'h1C, 8'h0C, 8'h04, 8'h84, 8'hC4, 8'hE4, 8'hF4,
    8'h60, 8'h88, 8'hA8, 8'h90, 8'h40, 8'h28, 8'hD0, 8'h08, 8'h20, 8'h78,
    8'hB0, 8'h48, 8'hE0, 8'hA0, 8'hF0, 8'h68, 8'hD8, 8'h50, 8'h10, 8'hC0,
    8'h30, 8'h18, 8'h70, 8'h98, 8'hB8, 8'hC8,
    8'h32, 8'h8C, 8'h56, 8'h16, 8'h54, 8'h94
  };
  // ? = . # $ /
  localparam logic [6:0] PUNCT [6] = '{7'h3F, 7'h3D, 7'h2E, 7'h23, 7'h24, 7'h2F};

  localparam out_item_t RES_QUIET = '0;
  localparam out_item_t RES_KEY_START =
    out_item_t'({1'b1, 1'b1, 1'b0, 7'd0, 1'b1, 1'b0});

  // One tick of stimulus; typed rows carry their own expected result
  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } row_t;

  // Stimulus bits are {dit, dah, word_detect}
  localparam row_t PLAN [N_ROWS] = '{
    {3'b000, 1'b1, RES_QUIET},
    {3'b001, 1'b1, RES_QUIET},
    {3'b100, 1'b1, RES_KEY_START},
    {3'b000, 1'b0, RES_QUIET}, {3'b000, 1'b0, RES_QUIET},
    {3'b000, 1'b0, RES_QUIET}, {3'b000, 1'b0, RES_QUIET},
    {3'b000, 1'b0, RES_QUIET},
    {3'b010, 1'b0, RES_QUIET},
    {3'b000, 1'b0, RES_QUIET}, {3'b000, 1'b0, RES_QUIET},
    {3'b000, 1'b0, RES_QUIET}, {3'b000, 1'b0, RES_QUIET},
    {3'b000, 1'b0, RES_QUIET},
    {3'b111, 1'b0, RES_QUIET}, {3'b111, 1'b0, RES_QUIET},
    {3'b111, 1'b0, RES_QUIET},
    {3'b001, 1'b0, RES_QUIET}, {3'b001, 1'b0, RES_QUIET},
    {3'b001, 1'b0, RES_QUIET}, {3'b001, 1'b0, RES_QUIET},
    {3'b001, 1'b0, RES_QUIET}, {3'b001, 1'b0, RES_QUIET},
    {3'b001, 1'b0, RES_QUIET}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // Sideband that travels with each item: typed expectation, if any
  logic      row_typed = 1'b0;
  out_item_t row_want = '0;

  logic      calm = 1'b0;
  int        phase_ticks;
  int        mismatches = 0;
  int        results_seen = 0;
  out_item_t keyer_outputs_due [$];

  // Keyer registers and state as the predictor sees them
  logic [1:0] mode_q;
  logic       swap_q;
  logic [7:0] bpd_q;
  logic       tx_en_q, tone_en_q, inv_q;
  phase_t     ph;
  logic [9:0] cd;
  logic [7:0] elem_bits;
  logic [3:0] elem_cnt;
  logic       word_pend;
  logic [1:0] latches, last_el, ult_mem;
  logic       tx_lvl, tone_lvl;

  iambic_keyer_with_decoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Decode a left-aligned pattern to ASCII, zero when it has no entry
  function automatic logic [6:0] morse_ascii(input logic [7:0] pattern);
    logic [6:0] ch;
    ch = 7'd0;
    for (int i = 0; i < 42; i++)
      if (SENT_PATTERNS[i] == pattern) begin
        if (i < 10) ch = 7'(7'h30 + i);
        else if (i < 36) ch = 7'(7'h41 + (i - 10));
        else ch = PUNCT[i - 36];
      end
    return ch;
  endfunction

  function automatic void latch_paddles(input in_item_t t);
    if (t.dit_pressed) latches = latches | (swap_q ? LATCH_DAH : LATCH_DIT);
    if (t.dah_pressed) latches = latches | (swap_q ? LATCH_DIT : LATCH_DAH);
  endfunction

  function automatic void key_level(input logic down);
    if (tone_en_q) tone_lvl = down;
    if (tx_en_q) tx_lvl = down;
  endfunction

  // Advance the keyer by one tick and return the outputs it shows
  function automatic out_item_t keyer_tick(input in_item_t t);
    out_item_t r;
    logic [9:0] dot;
    logic [15:0] pat;
    r = '0;
    dot = {2'b00, bpd_q};
    if (cd != 10'd0) cd = cd - 10'd1;
    if (!t.word_detect) word_pend = 1'b0;

    if (ph == PH_KEYED) begin
      if (mode_q == MODE_IAMBIC_B) latch_paddles(t);
      if (cd == 10'd0) begin
        key_level(1'b0);
        cd = dot;
        ph = PH_GAP;
      end
    end else if (ph == PH_GAP) begin
      latch_paddles(t);
      if (cd == 10'd0) begin
        ph = PH_IDLE;
        cd = dot;
        r.rx_return = ~t.word_detect;
      end
    end else begin
      ph = PH_IDLE;
      latch_paddles(t);
      // resolve squeezes per keyer mode
      if (mode_q == MODE_IAMBIC_A || mode_q == MODE_IAMBIC_B) begin
        latches = latches & ~last_el;
        last_el = 2'b00;
      end else if (mode_q == MODE_ULTIMATIC) begin
        if (latches == LATCH_BOTH) begin
          if (ult_mem != 2'b00) latches = latches & ~ult_mem;
          else latches = latches & LATCH_DAH;
        end else begin
          ult_mem = latches;
        end
      end else if (latches == LATCH_BOTH) begin
        latches = LATCH_DAH;
      end

      if (cd == 10'd0 && elem_cnt != 4'd0) begin
        // character gap: decode what was sent, long patterns give zero
        r.char_valid = 1'b1;
        if (elem_cnt <= 4'd7) begin
          pat = {7'd0, elem_bits, 1'b1} << (7 - elem_cnt);
          r.char_code = morse_ascii(pat[7:0]);
        end
        elem_bits = 8'd0;
        elem_cnt = 4'd0;
        cd = dot << 2;
        word_pend = 1'b1;
      end else if (cd == 10'd0 && word_pend) begin
        word_pend = 1'b0;
        r.char_valid = 1'b1;
        r.char_code = ASCII_SPACE;
      end else if (latches != 2'b00) begin
        // start the next element
        word_pend = 1'b0;
        if (elem_cnt != 4'd15) elem_cnt = elem_cnt + 4'd1;
        elem_bits = elem_bits << 1;
        if ((latches & LATCH_DIT) != 2'b00) begin
          cd = dot;
          last_el = LATCH_DIT;
        end else begin
          cd = dot + (dot << 1);
          last_el = LATCH_DAH;
          elem_bits[0] = 1'b1;
        end
        r.tx_start = ~t.word_detect;
        key_level(1'b1);
        latches = 2'b00;
        ph = PH_KEYED;
      end
    end

    r.tx_line = tx_lvl ^ inv_q;
    r.sidetone_on = tone_lvl;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [6:0] got,
                                 input logic [6:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH result %0d %s: got %0h, want %0h", results_seen, field, got, want);
  endtask

  // Track register writes, predict accepted items, check accepted results
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      mode_q = MODE_IAMBIC_A;
      swap_q = 1'b0;
      bpd_q = 8'd12;
      tx_en_q = 1'b1;
      tone_en_q = 1'b1;
      inv_q = 1'b0;
      ph = PH_IDLE;
      cd = '0;
      elem_bits = '0;
      elem_cnt = '0;
      word_pend = 1'b0;
      latches = '0;
      last_el = '0;
      ult_mem = '0;
      tx_lvl = 1'b0;
      tone_lvl = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEYER_MODE:      mode_q = cfg_data[1:0];
          CFG_PADDLE_SWAP:     swap_q = cfg_data[0];
          CFG_BEATS_PER_DOT:   bpd_q = cfg_data;
          CFG_TX_KEY_ENABLE:   tx_en_q = cfg_data[0];
          CFG_SIDETONE_ENABLE: tone_en_q = cfg_data[0];
          CFG_TX_INVERT:       inv_q = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (keyer_outputs_due.size() == 0) begin
          report_mismatch("unexpected item, char_code", out_data.char_code, 7'd0);
        end else begin
          want = keyer_outputs_due.pop_front();
          if (out_data.tx_line !== want.tx_line)
            report_mismatch("tx_line", 7'(out_data.tx_line), 7'(want.tx_line));
          if (out_data.sidetone_on !== want.sidetone_on)
            report_mismatch("sidetone_on", 7'(out_data.sidetone_on), 7'(want.sidetone_on));
          if (out_data.char_valid !== want.char_valid)
            report_mismatch("char_valid", 7'(out_data.char_valid), 7'(want.char_valid));
          if (out_data.char_code !== want.char_code)
            report_mismatch("char_code", out_data.char_code, want.char_code);
          if (out_data.tx_start !== want.tx_start)
            report_mismatch("tx_start", 7'(out_data.tx_start), 7'(want.tx_start));
          if (out_data.rx_return !== want.rx_return)
            report_mismatch("rx_return", 7'(out_data.rx_return), 7'(want.rx_return));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        want = keyer_tick(in_data);
        if (row_typed) want = row_want;
        keyer_outputs_due.push_back(want);
      end
    end
  end

  // Mostly no gap, some short, a few long; none while calm
  function automatic int pick_delay();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Stall the result side at random
  initial begin : sink
    int run, stall;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 12);
      stall = pick_delay();
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Present one item; valid stays high straight into the next item when there is no gap
  task automatic send_tick(input in_item_t t, input logic typed, input out_item_t want);
    int hold;
    hold = pick_delay();
    if (hold > 0) begin
      in_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_t c);
    put_reg(CFG_KEYER_MODE, {6'd0, c.keyer_mode});
    put_reg(CFG_PADDLE_SWAP, {7'd0, c.paddle_swap});
    put_reg(CFG_BEATS_PER_DOT, c.beats_per_dot);
    put_reg(CFG_TX_KEY_ENABLE, {7'd0, c.tx_key_enable});
    put_reg(CFG_SIDETONE_ENABLE, {7'd0, c.sidetone_enable});
    put_reg(CFG_TX_INVERT, {7'd0, c.tx_invert});
    cfg_valid <= 1'b0;
  endtask

  // Register settings per phase: fixed extremes first, then random
  function automatic cfg_t phase_cfg(input int p);
    cfg_t c;
    c.keyer_mode = 2'($urandom_range(0, 3));
    c.paddle_swap = 1'($urandom_range(0, 1));
    c.beats_per_dot = 8'($urandom_range(2, 6));
    c.tx_key_enable = ($urandom_range(0, 4) != 0);
    c.sidetone_enable = ($urandom_range(0, 4) != 0);
    c.tx_invert = 1'($urandom_range(0, 1));
    case (p)
      0: c = {MODE_IAMBIC_A, 1'b0, 8'd2, 1'b1, 1'b1, 1'b0};
      1: c = {MODE_IAMBIC_A, 1'b0, 8'd1, 1'b1, 1'b1, 1'b0};
      2: c = {MODE_IAMBIC_B, 1'b1, 8'd3, 1'b1, 1'b1, 1'b1};
      3: c = {MODE_ULTIMATIC, 1'b0, 8'd2, 1'b1, 1'b1, 1'b0};
      4: c = {MODE_DAH_PRIORITY, 1'b1, 8'd4, 1'b1, 1'b1, 1'b0};
      5: begin
        c.beats_per_dot = 8'd0;
        c.tx_key_enable = 1'b0;
        c.sidetone_enable = 1'b1;
        c.tx_invert = 1'b1;
      end
      6: begin
        c.beats_per_dot = 8'd255;
        c.tx_key_enable = 1'b1;
        c.sidetone_enable = 1'b0;
      end
      7: begin
        c.keyer_mode = MODE_ULTIMATIC;
        c.tx_key_enable = 1'b0;
        c.sidetone_enable = 1'b0;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Hold one paddle level for a number of ticks, or random levels when noisy
  task automatic hold_ticks(input in_item_t t, input int len, input int budget,
                            input logic noisy);
    in_item_t d;
    d = t;
    for (int k = 0; k < len && phase_ticks < budget; k++) begin
      if (noisy) begin
        d.dit_pressed = 1'($urandom_range(0, 1));
        d.dah_pressed = 1'($urandom_range(0, 1));
        d.word_detect = 1'($urandom_range(0, 1));
      end
      send_tick(d, 1'b0, RES_QUIET);
      phase_ticks++;
    end
  endtask

  // Mostly strokes timed in dots (press, then element, character or word gap), some noise
  task automatic random_phase(input int budget, input logic [7:0] bpd);
    in_item_t t;
    int dot, press_len, rest_len;
    logic wd;
    dot = (bpd == 8'd0) ? 1 : bpd;
    wd = 1'($urandom_range(0, 1));
    phase_ticks = 0;
    while (phase_ticks < budget) begin
      if ($urandom_range(0, 5) == 0) wd = ~wd;
      t = '0;
      t.word_detect = wd;
      if ($urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 4))
          0, 1: t.dit_pressed = 1'b1;
          2, 3: t.dah_pressed = 1'b1;
          default: begin
            t.dit_pressed = 1'b1;
            t.dah_pressed = 1'b1;
          end
        endcase
        // long holds run past seven elements
        press_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8 * dot, 30 * dot)
                                                : $urandom_range(1, 4 * dot + 1);
        rest_len = ($urandom_range(0, 3) == 0) ? $urandom_range(2 * dot, 12 * dot + 2)
                                               : $urandom_range(0, 2 * dot);
        hold_ticks(t, press_len, budget, 1'b0);
        t.dit_pressed = 1'b0;
        t.dah_pressed = 1'b0;
        hold_ticks(t, rest_len, budget, 1'b0);
      end else begin
        hold_ticks(t, $urandom_range(1, 8), budget, 1'b1);
      end
    end
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (keyer_outputs_due.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    cfg_t c;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < N_PHASES; p++) begin
      c = phase_cfg(p);
      calm <= (p % 4 == 3);
      write_cfg(c);
      if (p == 0) begin
        for (int i = 0; i < N_ROWS; i++)
          send_tick(PLAN[i].stim, PLAN[i].typed, PLAN[i].want);
      end else begin
        random_phase((c.beats_per_dot == 8'd255) ? 400 : 160, c.beats_per_dot);
      end
      drain();
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #LIMIT_NS;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
